>>> sv/pri_pkg.sv
// ---------------------------------------------------------------------------
// pri_pkg
// Types, register codes and saturating arithmetic for the particle ring
// integrator.
// ---------------------------------------------------------------------------
package pri_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned AGE_W    = 16;
  localparam int unsigned DAMP_W   = 16;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IN_DATA_W  = 192;
  localparam int unsigned OUT_DATA_W = 120;
  localparam int unsigned PROD_W   = WORD_W + DAMP_W + 1;

  localparam logic [AGE_W-1:0]  LIFETIME_RST = 16'd60;
  localparam logic [DAMP_W-1:0] DAMPING_RST  = 16'd32604;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIFETIME  = 3'd0,
    REG_GRAVITY_X = 3'd1,
    REG_GRAVITY_Y = 3'd2,
    REG_GRAVITY_Z = 3'd3,
    REG_DAMPING   = 3'd4
  } pri_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SWEEP = 2'd1,
    ST_DRAIN = 2'd2
  } pri_state_t;

  // x in element 0, y in 1, z in 2
  typedef logic [2:0][WORD_W-1:0] pri_vec_t;

  typedef struct packed {
    logic [AGE_W-1:0] age;
    pri_vec_t         pos;
    pri_vec_t         vel;
  } pri_entry_t;

  function automatic logic [WORD_W-1:0] sat_add(logic [WORD_W-1:0] a,
                                                logic [WORD_W-1:0] b);
    logic signed [WORD_W:0] s;
    s = $signed({a[WORD_W-1], a}) + $signed({b[WORD_W-1], b});
    if (s[WORD_W] != s[WORD_W-1]) begin
      return s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end
    return s[WORD_W-1:0];
  endfunction

  // Drop the 15 fraction bits (floor), then clamp to the signed word range.
  function automatic logic [WORD_W-1:0] sat_damp(logic [PROD_W-1:0] p);
    logic [PROD_W-16:0] q;
    q = p[PROD_W-1:15];
    if ((q[PROD_W-16:WORD_W-1] != '0) && (q[PROD_W-16:WORD_W-1] != '1)) begin
      return q[PROD_W-16] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end
    return q[WORD_W-1:0];
  endfunction

endpackage

>>> sv/particle_ring_integrator_top.sv
// ---------------------------------------------------------------------------
// particle_ring_integrator_top
// An emit item is written to the slot memory when it is accepted and makes
// no result; a tick item's slot reports pass from the read register through
// stages s1, s2 and s3 to the output register. Throughput: a tick streams
// PARTICLES reports, one slot a cycle while the output is not stalled,
// through the single read port of the slot memory, and the block takes no
// new item until the sweep has drained. Reset clears every live bit, the
// write slot and the control and config registers at once, not the slot memory.
// ---------------------------------------------------------------------------
module particle_ring_integrator_top #(
  parameter int unsigned PARTICLES = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (32 bits each)
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pri_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: action (0 emit, 1 tick)
  input  logic                             in_tuser,
  // out_tdata: slot[4:0], age[20:5], out_x[52:21], out_y[84:53],
  //            out_z[116:85], zero pad[119:117]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pri_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: active
  output logic                             out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pri_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pri_pkg::WORD_W-1:0]       cfg_data
);
  import pri_pkg::*;

  localparam int unsigned AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(PARTICLES - 1);

  // configuration
  logic [AGE_W-1:0]  lifetime_r;
  pri_vec_t          gravity_r;
  logic [DAMP_W-1:0] damping_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= LIFETIME_RST;
      gravity_r  <= '0;
      damping_r  <= DAMPING_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LIFETIME:  lifetime_r   <= cfg_data[AGE_W-1:0];
        REG_GRAVITY_X: gravity_r[0] <= cfg_data;
        REG_GRAVITY_Y: gravity_r[1] <= cfg_data;
        REG_GRAVITY_Z: gravity_r[2] <= cfg_data;
        REG_DAMPING:   damping_r    <= cfg_data[DAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  pri_state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r;
  logic [AW-1:0] write_slot_r;
  logic [PARTICLES-1:0] live_r;
  logic adv, issue;
  logic in_acc, emit_acc, tick_acc;
  logic pipe_busy;

  // pipeline stage registers
  logic          s1_v_r, s1_live_r, s1_last_r;
  logic [AW-1:0] s1_slot_r;
  pri_entry_t    rd_q_r;

  logic             s2_v_r, s2_upd_r, s2_last_r;
  logic [AW-1:0]    s2_slot_r;
  logic [AGE_W-1:0] s2_age_r;
  pri_vec_t         s2_pos_r, s2_vg_r;

  logic             s3_v_r, s3_upd_r, s3_last_r;
  logic [AW-1:0]    s3_slot_r;
  logic [AGE_W-1:0] s3_age_r;
  pri_vec_t         s3_pos_r;
  logic [2:0][PROD_W-1:0] s3_prod_r;

  logic                  out_valid_r, out_active_r, out_last_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign in_acc   = in_tvalid && in_tready;
  assign emit_acc = in_acc && !in_tuser;
  assign tick_acc = in_acc && in_tuser;
  assign adv      = !out_valid_r || out_tready;
  assign pipe_busy = s1_v_r || s2_v_r || s3_v_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (tick_acc) state_nxt = ST_SWEEP;
      ST_SWEEP: if (adv && (cnt_r == LAST_IDX)) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!pipe_busy) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    issue     = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_SWEEP: issue = adv;
      ST_DRAIN: ;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      write_slot_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (tick_acc) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= (cnt_r == LAST_IDX) ? '0 : cnt_r + 1'b1;
      end
      if (emit_acc) begin
        write_slot_r <= (write_slot_r == LAST_IDX) ? '0 : write_slot_r + 1'b1;
      end
    end
  end

  // slot memory: one write port, one registered read port
  pri_entry_t mem [PARTICLES];
  logic       mem_we;
  logic [AW-1:0] mem_wa;
  pri_entry_t mem_wd;
  pri_vec_t   vel_new;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      vel_new[c] = sat_damp(s3_prod_r[c]);
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = write_slot_r;
    mem_wd.age = '0;
    mem_wd.pos = in_tdata[3*WORD_W-1:0];
    mem_wd.vel = in_tdata[6*WORD_W-1:3*WORD_W];
    if (emit_acc) begin
      mem_we = 1'b1;
    end else if (adv && s3_v_r && s3_upd_r) begin
      // write back the integrated particle
      mem_we     = 1'b1;
      mem_wa     = s3_slot_r;
      mem_wd.age = s3_age_r;
      mem_wd.pos = s3_pos_r;
      mem_wd.vel = vel_new;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_q_r <= mem[cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else if (emit_acc) begin
      live_r[write_slot_r] <= 1'b1;
    end else if (adv && s3_v_r) begin
      // retire or keep; a dead slot stays dead
      live_r[s3_slot_r] <= s3_upd_r;
    end
  end

  // stage 1: age, position step, gravity
  logic [AGE_W-1:0] age_inc;
  logic             upd1;
  pri_vec_t         pos_n, vg_n;

  always_comb begin
    age_inc = rd_q_r.age + 1'b1;
    upd1    = s1_live_r && (age_inc != lifetime_r);
    for (int c = 0; c < 3; c++) begin
      pos_n[c] = sat_add(rd_q_r.pos[c], rd_q_r.vel[c]);
      vg_n[c]  = sat_add(rd_q_r.vel[c], gravity_r[c]);
    end
  end

  // stage 2: damping products, operands widened to the full product
  logic [2:0][PROD_W-1:0] prod_n;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_n[c] = $signed({{(PROD_W-WORD_W){s2_vg_r[c][WORD_W-1]}}, s2_vg_r[c]})
                * $signed({{(PROD_W-DAMP_W){1'b0}}, damping_r});
    end
  end

  // stage 3: result item
  logic [OUT_DATA_W-1:0] out_data_n;
  logic [AW+SLOT_W-1:0]  slot_ext;

  always_comb begin
    slot_ext   = {{SLOT_W{1'b0}}, s3_slot_r};
    out_data_n = '0;
    out_data_n[SLOT_W-1:0] = slot_ext[SLOT_W-1:0];
    if (s3_upd_r) begin
      out_data_n[SLOT_W+AGE_W-1:SLOT_W]                   = s3_age_r;
      out_data_n[SLOT_W+AGE_W+3*WORD_W-1:SLOT_W+AGE_W]    = s3_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= issue;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_slot_r <= cnt_r;
      s1_live_r <= live_r[cnt_r];
      s1_last_r <= (cnt_r == LAST_IDX);

      s2_slot_r <= s1_slot_r;
      s2_upd_r  <= upd1;
      s2_last_r <= s1_last_r;
      s2_age_r  <= age_inc;
      s2_pos_r  <= pos_n;
      s2_vg_r   <= vg_n;

      s3_slot_r <= s2_slot_r;
      s3_upd_r  <= s2_upd_r;
      s3_last_r <= s2_last_r;
      s3_age_r  <= s2_age_r;
      s3_pos_r  <= s2_pos_r;
      s3_prod_r <= prod_n;

      out_data_r   <= out_data_n;
      out_active_r <= s3_upd_r;
      out_last_r   <= s3_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_active_r;
  assign out_tlast  = out_last_r;

endmodule

>>> sv/pri_checker.sv
// ---------------------------------------------------------------------------
// pri_checker
// Port-level checks for the particle ring integrator, bound to the top level.
// ---------------------------------------------------------------------------
module pri_checker #(
  parameter int unsigned PARTICLES = 32
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [pri_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tuser,
  input logic                           out_tlast
);
  import pri_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'((PARTICLES - 1) % 32);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result item changed");

  // the final report of a tick is the last slot
  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[SLOT_W-1:0] == LAST_SLOT)
    else $error("tlast on wrong slot");

  // an inactive slot reports zero age and position
  a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[OUT_DATA_W-1:SLOT_W] == '0)
    else $error("inactive slot report not zero");

  // an emit starts no reports
  a_emit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> !$rose(out_tvalid))
    else $error("emit produced a report");

  // a tick holds off the next item
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("item accepted during a tick");

endmodule

bind particle_ring_integrator_top pri_checker #(.PARTICLES(PARTICLES)) u_pri_checker (.*);
